/* design/assert_macros.svh */
// assertion macros shared by the linear probe table insert rtl
// no dependencies; define SYNTH to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

/* design/lpti_pkg.sv */
// types, constants and helpers of the linear probe table insert block
// no dependencies
package lpti_pkg;

  // table storage, a power of two
  localparam int TableDepth   = 4096;
  localparam int AddrW        = $clog2(TableDepth);
  localparam int MinTableBits = 7;

  // fixed field widths
  localparam int TableBitsW = 4;
  localparam int HistW      = 8;
  localparam int HashW      = 32;
  localparam int PtrW       = 32;
  localparam int LitW       = 16;
  localparam int SlotW      = 12;
  localparam int LenW       = 17;
  localparam int StatusW    = 2;
  localparam int RamW       = PtrW + LenW;

  // config port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;
  localparam logic [CfgIdxW-1:0] CFG_TABLE_BITS  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HISTORY_LEN = 2'd1;
  localparam logic [TableBitsW-1:0] TABLE_BITS_RESET = 4'd12;

  // result status codes
  localparam logic [StatusW-1:0] STATUS_OK       = 2'd0;
  localparam logic [StatusW-1:0] STATUS_FULL     = 2'd1;
  localparam logic [StatusW-1:0] STATUS_ZERO_PTR = 2'd2;

  typedef enum logic [1:0] {
    OP_READ,
    OP_INSERT,
    OP_REJECT
  } op_e;

  // one classified request on its way to the back end
  typedef struct packed {
    op_e              op;
    logic [AddrW-1:0] slot;
    logic [PtrW-1:0]  ptr;
    logic [LenW-1:0]  len;
  } job_t;

  // configuration seen by the back end
  typedef struct packed {
    logic [AddrW-1:0] mask;
  } cfg_t;

  // back end status seen by the front end
  typedef struct packed {
    logic clearing;
  } back_status_t;

  // slot mask for a table_bits value, clamped to the legal table sizes
  function automatic logic [AddrW-1:0] table_mask(input logic [TableBitsW-1:0] bits);
    logic [AddrW-1:0] m;
    for (int i = 0; i < AddrW; i++) begin
      m[i] = (i < MinTableBits) || (i < int'(bits));
    end
    return m;
  endfunction

endpackage

/* design/lpti_ram.sv */
// generic simple dual port ram, one write port and one registered read port
// no dependencies
module lpti_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/lpti_front.sv */
// front end: config registers, request accept and classification
// depends on lpti_pkg
module lpti_front import lpti_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [CfgDataW-1:0]   cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  func_i,
  input  logic [HashW-1:0]      hash_i,
  input  logic [PtrW-1:0]       str_ptr_i,
  input  logic [LitW-1:0]       lit_pos_i,
  input  logic [SlotW-1:0]      slot_index_i,
  input  logic                  q_full_i,
  input  back_status_t          back_status_i,
  output logic                  push_o,
  output job_t                  job_o,
  output cfg_t                  cfg_o
);

  logic [TableBitsW-1:0] table_bits_q;
  logic [HistW-1:0]      hist_len_q;
  logic [AddrW-1:0]      mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_bits_q <= TABLE_BITS_RESET;
      hist_len_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TABLE_BITS:  table_bits_q <= cfg_data_i[TableBitsW-1:0];
        CFG_HISTORY_LEN: hist_len_q   <= cfg_data_i[HistW-1:0];
        default: ;
      endcase
    end
  end

  assign mask       = table_mask(table_bits_q);
  assign cfg_o.mask = mask;

  assign in_ready_o = !q_full_i && !back_status_i.clearing;
  assign push_o     = in_valid_i && in_ready_o;

  always_comb begin
    job_o.ptr = str_ptr_i;
    job_o.len = LenW'(lit_pos_i) + LenW'(hist_len_q);
    if (func_i) begin
      job_o.op   = OP_READ;
      job_o.slot = AddrW'(slot_index_i) & mask;
    end else begin
      job_o.op   = (str_ptr_i == '0) ? OP_REJECT : OP_INSERT;
      job_o.slot = hash_i[AddrW-1:0] & mask;
    end
  end

endmodule

/* design/lpti_fifo.sv */
// two entry request queue between front and back end
// depends on lpti_pkg and assert_macros.svh
`include "assert_macros.svh"
module lpti_fifo import lpti_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t head_o
);

  job_t       entries_q [2];
  logic       wptr_q;
  logic       rptr_q;
  logic [1:0] count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= '0;
    end else begin
      if (push_i) wptr_q <= !wptr_q;
      if (pop_i)  rptr_q <= !rptr_q;
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

  assign full_o  = count_q[1];
  assign valid_o = (count_q != '0);
  assign head_o  = entries_q[rptr_q];

  `ASSERT_NEVER(a_push_full, clk_i, rst_ni, push_i && full_o, "push into full queue")
  `ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, pop_i && !valid_o, "pop from empty queue")
  `ASSERT_NEVER(a_count_range, clk_i, rst_ni, count_q == 2'd3, "queue count beyond two")

endmodule

/* design/lpti_back.sv */
// back end: clearing pass, probe sequencer over the slot ram, result register
// depends on lpti_pkg, lpti_ram and assert_macros.svh
`include "assert_macros.svh"
module lpti_back import lpti_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                q_valid_i,
  input  job_t                q_head_i,
  output logic                pop_o,
  output back_status_t        status_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [StatusW-1:0]  status_code_o,
  output logic [SlotW-1:0]    slot_placed_o,
  output logic [PtrW-1:0]     slot_ptr_o,
  output logic [LenW-1:0]     slot_str_len_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE
  } state_e;

  state_e             state_q, state_d;
  job_t               job_q, job_d;
  logic [AddrW-1:0]   slot_q, slot_d;
  logic [AddrW-1:0]   probes_q, probes_d;
  logic [AddrW-1:0]   clr_addr_q, clr_addr_d;
  logic               out_valid_q, out_valid_d;
  logic [StatusW-1:0] out_status_q, out_status_d;
  logic [SlotW-1:0]   out_slot_q, out_slot_d;
  logic [PtrW-1:0]    out_ptr_q, out_ptr_d;
  logic [LenW-1:0]    out_len_q, out_len_d;

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [RamW-1:0]  ram_wdata;
  logic [AddrW-1:0] ram_raddr;
  logic [RamW-1:0]  ram_rdata;
  logic [PtrW-1:0]  rd_ptr;
  logic [LenW-1:0]  rd_len;
  logic             out_free;

  lpti_ram #(
    .Width(RamW),
    .Depth(TableDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_ptr   = ram_rdata[RamW-1:LenW];
  assign rd_len   = ram_rdata[LenW-1:0];
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d      = state_q;
    job_d        = job_q;
    slot_d       = slot_q;
    probes_d     = probes_q;
    clr_addr_d   = clr_addr_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_ptr_d    = out_ptr_q;
    out_len_d    = out_len_q;
    pop_o        = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = slot_q;
    ram_wdata    = {job_q.ptr, job_q.len};
    ram_raddr    = slot_q;
    case (state_q)
      ST_CLEAR: begin
        ram_we     = 1'b1;
        ram_waddr  = clr_addr_q;
        ram_wdata  = '0;
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid_i && out_free) begin
          pop_o    = 1'b1;
          job_d    = q_head_i;
          slot_d   = q_head_i.slot;
          probes_d = '0;
          case (q_head_i.op)
            OP_REJECT: begin
              out_valid_d  = 1'b1;
              out_status_d = STATUS_ZERO_PTR;
              out_slot_d   = '0;
              out_ptr_d    = '0;
              out_len_d    = '0;
            end
            OP_READ, OP_INSERT: begin
              ram_raddr = q_head_i.slot;
              state_d   = ST_PROBE;
            end
            default: ;
          endcase
        end
      end
      ST_PROBE: begin
        if (job_q.op == OP_READ) begin
          out_valid_d  = 1'b1;
          out_status_d = STATUS_OK;
          out_slot_d   = SlotW'(slot_q);
          out_ptr_d    = rd_ptr;
          out_len_d    = rd_len;
          state_d      = ST_IDLE;
        end else if (rd_ptr == '0) begin
          // first empty slot found
          ram_we       = 1'b1;
          out_valid_d  = 1'b1;
          out_status_d = STATUS_OK;
          out_slot_d   = SlotW'(slot_q);
          out_ptr_d    = job_q.ptr;
          out_len_d    = job_q.len;
          state_d      = ST_IDLE;
        end else if (probes_q == cfg_i.mask) begin
          // every slot in use is occupied
          out_valid_d  = 1'b1;
          out_status_d = STATUS_FULL;
          out_slot_d   = '0;
          out_ptr_d    = '0;
          out_len_d    = '0;
          state_d      = ST_IDLE;
        end else begin
          slot_d    = (slot_q + 1'b1) & cfg_i.mask;
          probes_d  = probes_q + 1'b1;
          ram_raddr = slot_d;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q        <= job_d;
    slot_q       <= slot_d;
    probes_q     <= probes_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_ptr_q    <= out_ptr_d;
    out_len_q    <= out_len_d;
  end

  assign status_o.clearing = (state_q == ST_CLEAR);
  assign out_valid_o       = out_valid_q;
  assign status_code_o     = out_status_q;
  assign slot_placed_o     = out_slot_q;
  assign slot_ptr_o        = out_ptr_q;
  assign slot_str_len_o    = out_len_q;

  `ASSERT_NEVER(a_probe_out_busy, clk_i, rst_ni, (state_q == ST_PROBE) && out_valid_q,
      "result register busy during probe")
  `ASSERT_NEVER(a_probe_overrun, clk_i, rst_ni,
      (state_q == ST_PROBE) && ((probes_q & ~cfg_i.mask) != '0), "probe count beyond size")
  `ASSERT_PROP(a_pop_idle, clk_i, rst_ni, pop_o |-> (state_q == ST_IDLE),
      "queue popped outside idle")
  `ASSERT_PROP(a_clear_done, clk_i, rst_ni,
      ((state_q == ST_CLEAR) && (clr_addr_q == '1)) |=> (state_q == ST_IDLE),
      "clearing pass did not end")

endmodule

/* design/linear_probe_table_insert_top.sv */
// top level of the linear probe table insert engine
// depends on lpti_pkg, lpti_front, lpti_fifo, lpti_back (which holds lpti_ram)
//
//  channel   direction  handshake                 payload
//  config    in         cfg_we_i                  cfg_idx_i, cfg_data_i
//  request   in         in_valid_i / in_ready_o   func, hash, str_ptr, lit_pos, slot_index
//  result    out        out_valid_o / out_ready_i status, slot_placed, slot_ptr, slot_str_len
//
// after reset a clearing pass zeroes the slot ram, one slot a cycle, all TableDepth
// (4096) slots; in_ready_o stays low meanwhile, config writes still land
// per request at the head of the queue: zero pointer rejected with no ram read, read one
// ram read, insert one ram read per cycle to an empty slot, full table every slot in use
// the two entry queue takes requests while the back end probes or its result waits
// results sit in an output register; the back end starts a request only when it is free
module linear_probe_table_insert_top import lpti_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // config write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // request channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                func_i,
  input  logic [HashW-1:0]    hash_i,
  input  logic [PtrW-1:0]     str_ptr_i,
  input  logic [LitW-1:0]     lit_pos_i,
  input  logic [SlotW-1:0]    slot_index_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [StatusW-1:0]  status_o,
  output logic [SlotW-1:0]    slot_placed_o,
  output logic [PtrW-1:0]     slot_ptr_o,
  output logic [LenW-1:0]     slot_str_len_o
);

  // front to queue
  logic         push;
  job_t         job;
  logic         q_full;
  // queue to back
  logic         q_valid;
  logic         pop;
  job_t         q_head;
  // side band between the two ends
  cfg_t         cfg;
  back_status_t back_status;

  // accepts requests, holds table size and history length, classifies
  // each request as read, insert or zero pointer reject
  lpti_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .hash_i       (hash_i),
    .str_ptr_i    (str_ptr_i),
    .lit_pos_i    (lit_pos_i),
    .slot_index_i (slot_index_i),
    .q_full_i     (q_full),
    .back_status_i(back_status),
    .push_o       (push),
    .job_o        (job),
    .cfg_o        (cfg)
  );

  // decouples request accept from the probe walk
  lpti_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job),
    .full_o (q_full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .head_o (q_head)
  );

  // walks the table one slot per cycle and drives the result register
  lpti_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .q_valid_i        (q_valid),
    .q_head_i         (q_head),
    .pop_o            (pop),
    .status_o         (back_status),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_code_o    (status_o),
    .slot_placed_o    (slot_placed_o),
    .slot_ptr_o       (slot_ptr_o),
    .slot_str_len_o   (slot_str_len_o)
  );

endmodule

/* tb/sv/tb_linear_probe_table_insert_top.sv */
`timescale 1ns / 1ps
// self-checking testbench of linear_probe_table_insert_top: inserts and slot reads
// checked against a slot table model kept here; depends on lpti_pkg and the rtl
module tb_linear_probe_table_insert_top;
  import lpti_pkg::*;

  // request function codes as seen on func_i
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_READ   = 1'b1;
  // index with no register behind it, writes there must change nothing
  localparam logic [CfgIdxW-1:0] CFG_SPARE_IDX = 2'd3;
  localparam int MaxShown         = 10;
  localparam int ItemsPerSetting  = 65;
  localparam int EndHoldCycles    = 16;

  // one result as the block should return it
  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [SlotW-1:0]   slot;
    logic [PtrW-1:0]    ptr;
    logic [LenW-1:0]    len;
  } slot_result_t;

  // dut ports, every input known from time zero
  logic                clk_i;
  logic                rst_ni       = 1'b0;
  logic                cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i    = '0;
  logic [CfgDataW-1:0] cfg_data_i   = '0;
  logic                in_valid_i   = 1'b0;
  logic                in_ready_o;
  logic                func_i       = FUNC_READ;
  logic [HashW-1:0]    hash_i       = '0;
  logic [PtrW-1:0]     str_ptr_i    = '0;
  logic [LitW-1:0]     lit_pos_i    = '0;
  logic [SlotW-1:0]    slot_index_i = '0;
  logic                out_valid_o;
  logic                out_ready_i  = 1'b0;
  logic [StatusW-1:0]  status_o;
  logic [SlotW-1:0]    slot_placed_o;
  logic [PtrW-1:0]     slot_ptr_o;
  logic [LenW-1:0]     slot_str_len_o;

  // slot table model and its registers
  logic [PtrW-1:0]       model_ptr [TableDepth] = '{default: '0};
  logic [LenW-1:0]       model_len [TableDepth] = '{default: '0};
  logic [TableBitsW-1:0] model_table_bits = TABLE_BITS_RESET;
  logic [HistW-1:0]      model_history    = '0;

  // results still owed by the block, oldest first
  slot_result_t expected_results [$];

  int              fail_count  = 0;
  int              tx_idle_pct = 29;
  int              rx_idle_pct = 76;
  int unsigned     last_slot   = 0;
  longint unsigned cycle_count = 0;
  // grows with every accepted request; starts with room for the clearing pass
  longint unsigned cycle_limit = 4 * (TableDepth + 2000);

  linear_probe_table_insert_top uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .func_i            (func_i),
    .hash_i            (hash_i),
    .str_ptr_i         (str_ptr_i),
    .lit_pos_i         (lit_pos_i),
    .slot_index_i      (slot_index_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .slot_placed_o     (slot_placed_o),
    .slot_ptr_o        (slot_ptr_o),
    .slot_str_len_o    (slot_str_len_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // slots in use: below 7 bits counts as 7, anything past the storage as the storage
  function automatic int unsigned active_size();
    int unsigned bits;
    bits = model_table_bits;
    if (bits < MinTableBits) bits = MinTableBits;
    if (bits > AddrW) bits = AddrW;
    return 1 << bits;
  endfunction

  // result of one request; an insert also lands in the model table
  function automatic slot_result_t predict_slot_result(input logic f,
                                                       input logic [HashW-1:0] h,
                                                       input logic [PtrW-1:0] p,
                                                       input logic [LitW-1:0] lit,
                                                       input logic [SlotW-1:0] idx);
    slot_result_t r;
    int unsigned size, mask, slot, probes;
    size = active_size();
    mask = size - 1;
    r = '0;
    if (f == FUNC_READ) begin
      // read index wraps at the current size
      slot = idx & mask;
      r.status = STATUS_OK;
      r.slot   = SlotW'(slot);
      r.ptr    = model_ptr[slot];
      r.len    = model_len[slot];
    end else if (p == '0) begin
      // zero pointer would look like an empty slot, so it is turned away
      r.status = STATUS_ZERO_PTR;
    end else begin
      // walk forward over occupied slots, wrapping at the top
      slot   = h & mask;
      probes = 0;
      while (probes < size && model_ptr[slot] != '0) begin
        slot = (slot + 1) & mask;
        probes++;
      end
      if (probes == size) begin
        r.status = STATUS_FULL;
      end else begin
        model_ptr[slot] = p;
        model_len[slot] = LenW'(lit) + LenW'(model_history);
        r.status = STATUS_OK;
        r.slot   = SlotW'(slot);
        r.ptr    = p;
        r.len    = model_len[slot];
      end
    end
    return r;
  endfunction

  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= MaxShown) $display("%s", what);
  endtask

  // one register write; we stays high so back to back writes need no gap
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_TABLE_BITS:  model_table_bits = data[TableBitsW-1:0];
      CFG_HISTORY_LEN: model_history    = data[HistW-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [CfgDataW-1:0] bits_data,
                           input logic [CfgDataW-1:0] hist_data);
    write_reg(CFG_TABLE_BITS, bits_data);
    write_reg(CFG_HISTORY_LEN, hist_data);
    cfg_we_i <= 1'b0;
  endtask

  // stop requesting and wait until every owed result is back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // hand one request over and log what it should produce
  task automatic send_request(input logic f, input logic [HashW-1:0] h,
                              input logic [PtrW-1:0] p, input logic [LitW-1:0] lit,
                              input logic [SlotW-1:0] idx, output logic [StatusW-1:0] st);
    slot_result_t want;
    // random gap before the request, valid low meanwhile
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= f;
    hash_i       <= h;
    str_ptr_i    <= p;
    lit_pos_i    <= lit;
    slot_index_i <= idx;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    // accepted at this edge; config cannot change while requests are in flight
    want = predict_slot_result(f, h, p, lit, idx);
    expected_results.push_back(want);
    if (f == FUNC_INSERT && want.status == STATUS_OK) last_slot = want.slot;
    // worst case: a full probe of the table plus long stalls on both sides
    cycle_limit += 4 * (active_size() + 200);
    st = want.status;
  endtask

  task automatic send_random_insert(output logic [StatusW-1:0] st);
    logic [HashW-1:0] h;
    logic [PtrW-1:0]  p;
    logic [LitW-1:0]  lit;
    int unsigned      mask;
    mask = active_size() - 1;
    h = $urandom;
    // half the hashes start near the top so the probe may have to wrap
    if ($urandom_range(0, 1) == 1) h = (h & ~mask) | ((mask - $urandom_range(0, 3)) & mask);
    case ($urandom_range(0, 9))
      0:       p = '1;
      1:       p = 32'd1;
      default: p = $urandom;
    endcase
    if (p == '0) p = 32'd1;
    case ($urandom_range(0, 9))
      0:       lit = '0;
      1:       lit = '1;
      default: lit = LitW'($urandom);
    endcase
    send_request(FUNC_INSERT, h, p, lit, SlotW'($urandom), st);
  endtask

  task automatic send_random_read(output logic [StatusW-1:0] st);
    logic [SlotW-1:0] idx;
    // either anywhere or right around the latest placement
    if ($urandom_range(0, 1) == 1) idx = SlotW'($urandom);
    else idx = SlotW'(last_slot + $urandom_range(0, 2));
    send_request(FUNC_READ, $urandom, $urandom, LitW'($urandom), idx, st);
  endtask

  // field extremes, both functions, size clamping, wrap and zero pointer
  task automatic test_directed_cases();
    logic [StatusW-1:0] st;
    wait_drained();
    // 0 table bits acts as the 128 slot minimum, longest history
    configure(8'd0, 8'hFF);
    send_request(FUNC_READ, '0, '0, '0, '0, st);   // empty slot
    send_request(FUNC_READ, '1, '1, '1, '1, st);   // index wraps to slot 127
    send_request(FUNC_INSERT, '1, '0, '1, '1, st); // zero pointer turned away
    send_request(FUNC_INSERT, '1, '1, '1, '0, st); // top slot, longest length
    send_request(FUNC_INSERT, '1, 32'd1, '0, '1, st);  // top taken, wraps to 0
    send_request(FUNC_INSERT, '0, 32'h8000_0000, 16'h8000, '0, st);
    send_request(FUNC_INSERT, 32'h0000_0080, 32'h5A5A_A5A5, 16'h00FF, '0, st); // hash past size
    send_request(FUNC_READ, '0, '0, '0, 12'd127, st);
    send_request(FUNC_READ, '0, '0, '0, 12'd1, st);
    send_request(FUNC_READ, '0, '0, '0, 12'd2, st);
    send_request(FUNC_READ, '0, '0, '0, 12'd128, st);  // wraps to slot 0
    wait_drained();
    // spare index must be ignored; 15 table bits clamps to the whole storage
    write_reg(CFG_SPARE_IDX, 8'hFF);
    configure(8'd15, 8'd0);
    send_request(FUNC_INSERT, 32'h0000_0FFF, 32'hC0DE_F00D, '1, '0, st);
    send_request(FUNC_INSERT, 32'hFFFF_F07F, 32'h0000_FFFF, 16'h1234, '0, st); // 127 taken
    send_request(FUNC_READ, '0, '0, '0, '1, st);
    send_request(FUNC_READ, '0, '0, '0, 12'd128, st);
    send_request(FUNC_READ, '0, '0, '0, 12'd127, st);
    wait_drained();
    // back down to 128 slots with upper data bits set; upper slots stay stored
    configure(8'hF7, 8'd1);
    send_request(FUNC_READ, '0, '0, '0, '1, st);
    send_request(FUNC_INSERT, 32'h0000_007F, 32'h0F0F_0F0F, 16'hFFFE, '0, st);
  endtask

  // fill the smallest table, then keep inserting into it
  task automatic test_table_full();
    logic [StatusW-1:0] st;
    wait_drained();
    configure(8'd7, CfgDataW'($urandom));
    do begin
      if ($urandom_range(0, 3) == 0) send_random_read(st);
      send_random_insert(st);
    end while (st != STATUS_FULL);
    repeat (4) send_random_insert(st);
    send_request(FUNC_INSERT, '1, '0, '1, '0, st); // zero pointer wins over full
    send_random_read(st);
  endtask

  // mixed traffic under three table sizes with one idle pattern
  task automatic test_random_traffic(input int tx_pct, input int rx_pct,
                                     input logic [CfgDataW-1:0] bits_a,
                                     input logic [CfgDataW-1:0] bits_b,
                                     input logic [CfgDataW-1:0] bits_c);
    logic [CfgDataW-1:0] bits_set [3];
    logic [CfgDataW-1:0] hist;
    logic [StatusW-1:0]  st;
    int                  pick;
    bits_set    = '{bits_a, bits_b, bits_c};
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    foreach (bits_set[s]) begin
      wait_drained();
      case ($urandom_range(0, 3))
        0:       hist = '0;
        1:       hist = '1;
        default: hist = CfgDataW'($urandom);
      endcase
      configure(bits_set[s], hist);
      repeat (ItemsPerSetting) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) send_random_read(st);
        else if (pick < 45)
          send_request(FUNC_INSERT, $urandom, '0, LitW'($urandom), SlotW'($urandom), st);
        else send_random_insert(st);
      end
    end
  endtask

  // result side: compare each accepted result, then draw the next ready
  always @(posedge clk_i) begin : result_check
    slot_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        note_failure($sformatf("unexpected result: status %0d slot %0d ptr %h len %0d",
                               status_o, slot_placed_o, slot_ptr_o, slot_str_len_o));
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status || slot_placed_o !== want.slot ||
            slot_ptr_o !== want.ptr || slot_str_len_o !== want.len) begin
          note_failure($sformatf(
            "mismatch: expected status %0d slot %0d ptr %h len %0d, got %0d %0d %h %0d",
            want.status, want.slot, want.ptr, want.len,
            status_o, slot_placed_o, slot_ptr_o, slot_str_len_o));
        end
      end
    end
    out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // hang guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_linear_probe_table_insert_top: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // requests wait on in_ready_o through the clearing pass
    test_directed_cases();
    test_table_full();
    // sender idles lightly, receiver heavily; then swapped; then no idling
    test_random_traffic(29, 76, 8'd8, 8'd7, 8'd9);
    test_random_traffic(76, 29, 8'd5, 8'd12, 8'd10);
    test_random_traffic(0, 0, 8'd15, 8'd11, 8'hA9);
    wait_drained();
    // keep clocking to catch anything extra coming out
    repeat (EndHoldCycles) @(posedge clk_i);
    if (expected_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", expected_results.size()));
    if (fail_count == 0) begin
      $display("tb_linear_probe_table_insert_top: PASS");
    end else begin
      $display("tb_linear_probe_table_insert_top: FAIL");
    end
    $finish;
  end

endmodule
